// File: hdl/nwsc_pkg.sv
// ----------------------------------------------------------------------------
// nwsc_pkg
// Shared widths, codes and reset values for the nose wheel steering slew core.
// ----------------------------------------------------------------------------
package nwsc_pkg;

  // field widths
  localparam int AUTH_W    = 10;
  localparam int ANGLE_W   = 13;
  localparam int LIGHT_W   = 8;
  localparam int RATIO_W   = 16;
  localparam int PROP_W    = 12;
  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // light reciprocal: floor(n / max) = (n * ceil(2^SHIFT / max)) >> SHIFT
  // exact for n < 2^18 and max < 2^10
  localparam int LNUM_W    = AUTH_W + LIGHT_W;        // authority * 255
  localparam int RECIP_SH  = LNUM_W + AUTH_W;         // 28
  localparam int RECIP_W   = RECIP_SH + 1;            // 29

  localparam logic signed [ANGLE_W-1:0] STEER_LIMIT = 13'sd3150;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVER_THRESHOLD = 3'd0,
    CFG_AUTHORITY_STEP  = 3'd1,
    CFG_AUTHORITY_MIN   = 3'd2,
    CFG_AUTHORITY_MAX   = 3'd3,
    CFG_SLEW_STEP       = 3'd4,
    CFG_SNAP_BAND       = 3'd5
  } cfg_index_t;

  // reset values
  localparam logic [PROP_W-1:0] RST_LEVER_THRESHOLD = 12'd1170;
  localparam logic [AUTH_W-1:0] RST_AUTHORITY_STEP  = 10'd50;
  localparam logic [AUTH_W-1:0] RST_AUTHORITY_MIN   = 10'd120;
  localparam logic [AUTH_W-1:0] RST_AUTHORITY_MAX   = 10'd630;
  localparam logic [STEP_W-1:0] RST_SLEW_STEP       = 8'd5;
  localparam logic [STEP_W-1:0] RST_SNAP_BAND       = 8'd6;

  // arm switch and poll codes
  localparam logic [1:0] ARM_ON     = 2'd1;
  localparam logic [1:0] POLL_IDLE  = 2'd0;
  localparam logic [1:0] POLL_ARMED = 2'd1;
  localparam logic [1:0] POLL_SLEW  = 2'd2;

endpackage

// File: hdl/nwsc_recip.sv
// ----------------------------------------------------------------------------
// nwsc_recip
// Restoring divider, one quotient bit a cycle: recip = ceil(2^RECIP_SH / divisor).
// ----------------------------------------------------------------------------
module nwsc_recip (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [nwsc_pkg::AUTH_W-1:0]       divisor,
  output logic                              busy,
  output logic [nwsc_pkg::RECIP_W-1:0]      recip
);

  localparam int CNT_W = $clog2(nwsc_pkg::RECIP_W + 1);

  logic [nwsc_pkg::RECIP_W-1:0] num;
  logic [nwsc_pkg::AUTH_W-1:0]  rem;
  logic [CNT_W-1:0]             cnt;
  logic [nwsc_pkg::AUTH_W:0]    rem_sh;
  logic                         q_bit;
  logic [nwsc_pkg::AUTH_W:0]    rem_sub;

  // one trial subtract per cycle
  always_comb begin
    rem_sh  = {rem, num[nwsc_pkg::RECIP_W-1]};
    q_bit   = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(nwsc_pkg::RECIP_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: dividend 2^SH + d - 1 shifts out, quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      num <= (nwsc_pkg::RECIP_W'(1) << nwsc_pkg::RECIP_SH)
             + nwsc_pkg::RECIP_W'(divisor) - 1'b1;
      rem <= '0;
    end else if (busy) begin
      num <= {num[nwsc_pkg::RECIP_W-2:0], q_bit};
      rem <= q_bit ? rem_sub[nwsc_pkg::AUTH_W-1:0] : rem_sh[nwsc_pkg::AUTH_W-1:0];
    end
  end

  assign recip = num;

endmodule

// File: hdl/nose_wheel_steering_slew_control_core.sv
// ----------------------------------------------------------------------------
// nose_wheel_steering_slew_control_core
// Per-tick steering authority ramp, command scaling and steer angle slew.
//
//   channel   direction  handshake                 word
//   s_*       in         s_tvalid / s_tready       one control tick
//   m_*       out        m_tvalid / m_tready       one steering result
//   cfg_*     in         cfg_valid / cfg_ready     register index + data
//
// One word per cycle while m_tready is high and the divider idle; m_tvalid rises
// once the word passes the input reg, authority ramp + ratio multiply, scaling +
// light and slew/output registers. After reset and each write to authority_max,
// the light reciprocal divider runs with s_tready low; cfg writes always taken.
// Each stage advances when the next is empty or moving, so input keeps
// flowing while a result waits on m_tready until the pipe fills.
// ----------------------------------------------------------------------------
module nose_wheel_steering_slew_control_core (
  input  logic                                clk,
  input  logic                                rst,
  // gear_down[0], arm_switch[2:1], park_switch[3], engage_switch[4],
  // heading_ratio[20:5], prop_speed[32:21], zero[39:33]
  input  logic [39:0]                         s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // steer_angle[12:0], steer_enabled[13], annunciator_on[14],
  // park_light[22:15], poll_mode[24:23], zero[31:25]
  output logic [31:0]                         m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nwsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nwsc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int AW = nwsc_pkg::AUTH_W;
  localparam int GW = nwsc_pkg::ANGLE_W;

  // configuration registers
  logic [nwsc_pkg::PROP_W-1:0] lever_threshold;
  logic [AW-1:0]               authority_step;
  logic [AW-1:0]               authority_min;
  logic [AW-1:0]               authority_max;
  logic [nwsc_pkg::STEP_W-1:0] slew_step;
  logic [nwsc_pkg::STEP_W-1:0] snap_band;
  logic                        recip_start;
  logic                        recip_busy;
  logic [nwsc_pkg::RECIP_W-1:0] recip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lever_threshold <= nwsc_pkg::RST_LEVER_THRESHOLD;
      authority_step  <= nwsc_pkg::RST_AUTHORITY_STEP;
      authority_min   <= nwsc_pkg::RST_AUTHORITY_MIN;
      authority_max   <= nwsc_pkg::RST_AUTHORITY_MAX;
      slew_step       <= nwsc_pkg::RST_SLEW_STEP;
      snap_band       <= nwsc_pkg::RST_SNAP_BAND;
      recip_start     <= 1'b1;
    end else begin
      recip_start <= cfg_valid && cfg_ready &&
                     (nwsc_pkg::cfg_index_t'(cfg_index) == nwsc_pkg::CFG_AUTHORITY_MAX);
      if (cfg_valid && cfg_ready) begin
        case (nwsc_pkg::cfg_index_t'(cfg_index))
          nwsc_pkg::CFG_LEVER_THRESHOLD: lever_threshold <= cfg_data;
          nwsc_pkg::CFG_AUTHORITY_STEP:  authority_step  <= cfg_data[AW-1:0];
          nwsc_pkg::CFG_AUTHORITY_MIN:   authority_min   <= cfg_data[AW-1:0];
          nwsc_pkg::CFG_AUTHORITY_MAX:   authority_max   <= cfg_data[AW-1:0];
          nwsc_pkg::CFG_SLEW_STEP:       slew_step <= cfg_data[nwsc_pkg::STEP_W-1:0];
          nwsc_pkg::CFG_SNAP_BAND:       snap_band <= cfg_data[nwsc_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // reciprocal of authority_max for the park light
  nwsc_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (recip_start),
    .divisor (authority_max),
    .busy    (recip_busy),
    .recip   (recip)
  );

  // pipeline flow control
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3;
  logic s_fire, f01, f12, f23;

  always_comb begin
    rdy3     = !v3 || m_tready;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    rdy0     = !v0 || rdy1;
    s_tready = rdy0 && !recip_busy && !recip_start;
    s_fire   = s_tvalid && s_tready;
    f01      = v0 && rdy1;
    f12      = v1 && rdy2;
    f23      = v2 && rdy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= s_fire || (v0 && !f01);
      v1 <= f01 || (v1 && !f12);
      v2 <= f12 || (v2 && !f23);
      v3 <= f23 || (v3 && !(m_tready));
    end
  end

  // stage 0: input register
  logic                               in_gear;
  logic [1:0]                         in_arm;
  logic                               in_park;
  logic                               in_engage;
  logic signed [nwsc_pkg::RATIO_W-1:0] in_ratio;
  logic [nwsc_pkg::PROP_W-1:0]        in_prop;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_gear   <= s_tdata[0];
      in_arm    <= s_tdata[2:1];
      in_park   <= s_tdata[3];
      in_engage <= s_tdata[4];
      in_ratio  <= $signed(s_tdata[20:5]);
      in_prop   <= s_tdata[32:21];
    end
  end

  // stage 1: authority ramp, steering flag, ratio * authority
  logic [AW-1:0] auth;
  logic          steer_on;
  logic [AW-1:0] auth_next;
  logic          taken_next;
  logic          active_next;
  logic          cmd_en_next;
  logic          steer_on_next;
  logic [AW:0]   up_sum;
  logic [AW:0]   down_lim;

  always_comb begin
    active_next   = in_gear && (in_arm == nwsc_pkg::ARM_ON);
    up_sum        = {1'b0, auth} + {1'b0, authority_step};
    down_lim      = {1'b0, authority_min} + {1'b0, authority_step};
    auth_next     = auth;
    taken_next    = 1'b0;
    cmd_en_next   = 1'b0;
    steer_on_next = steer_on;
    if (active_next) begin
      if (in_park && (auth < authority_max)) begin
        taken_next = 1'b1;
        auth_next  = (up_sum > {1'b0, authority_max}) ? authority_max : up_sum[AW-1:0];
      end else if (!in_park && (auth > authority_min)) begin
        taken_next = 1'b1;
        auth_next  = ({1'b0, auth} < down_lim) ? authority_min : auth - authority_step;
      end
      if (in_engage || (in_prop < lever_threshold)) begin
        cmd_en_next   = 1'b1;
        steer_on_next = 1'b1;
      end
    end else begin
      steer_on_next = 1'b0;
    end
  end

  logic                 s1_active;
  logic                 s1_taken;
  logic                 s1_cmd_en;
  logic                 s1_flag;
  logic [AW-1:0]        s1_auth;
  logic signed [26:0]   s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      auth     <= nwsc_pkg::RST_AUTHORITY_MIN;
      steer_on <= 1'b0;
    end else if (f01) begin
      auth     <= auth_next;
      steer_on <= steer_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (f01) begin
      s1_active <= active_next;
      s1_taken  <= taken_next;
      s1_cmd_en <= cmd_en_next;
      s1_flag   <= steer_on_next;
      s1_auth   <= auth_next;
      s1_prod   <= 27'(in_ratio) * 27'($signed({1'b0, auth_next}));
    end
  end

  // stage 2: command scaling (x5, /32768 toward zero, clamp) and park light
  logic signed [28:0]    p5;
  logic signed [28:0]    p5_adj;
  logic signed [13:0]    cmd_q;
  logic signed [GW-1:0]  cmd_next;
  logic [nwsc_pkg::LNUM_W-1:0] light_num;
  logic [nwsc_pkg::LNUM_W+nwsc_pkg::RECIP_W-1:0] light_prod;
  logic [nwsc_pkg::LNUM_W+nwsc_pkg::RECIP_W-nwsc_pkg::RECIP_SH-1:0] light_q;
  logic [nwsc_pkg::LIGHT_W-1:0] light_next;
  logic [nwsc_pkg::LIGHT_W-1:0] light_level;

  always_comb begin
    p5     = (29'(s1_prod) <<< 2) + 29'(s1_prod);
    p5_adj = p5[28] ? (p5 + 29'sd32767) : p5;
    cmd_q  = 14'(p5_adj >>> 15);
    if (!s1_cmd_en) begin
      cmd_next = '0;
    end else if (cmd_q > 14'(nwsc_pkg::STEER_LIMIT)) begin
      cmd_next = nwsc_pkg::STEER_LIMIT;
    end else if (cmd_q < -14'(nwsc_pkg::STEER_LIMIT)) begin
      cmd_next = -nwsc_pkg::STEER_LIMIT;
    end else begin
      cmd_next = cmd_q[GW-1:0];
    end

    // light = authority * 255 / max, clamped; zero max reads full scale
    light_num  = ({s1_auth, 8'd0} - nwsc_pkg::LNUM_W'(s1_auth));
    light_prod = light_num * recip;
    light_q    = light_prod[nwsc_pkg::LNUM_W+nwsc_pkg::RECIP_W-1:nwsc_pkg::RECIP_SH];
    if (!s1_taken) begin
      light_next = light_level;
    end else if (authority_max == '0 || light_q > 255) begin
      light_next = '1;
    end else begin
      light_next = light_q[nwsc_pkg::LIGHT_W-1:0];
    end
  end

  logic                 s2_active;
  logic                 s2_flag;
  logic signed [GW-1:0] s2_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_level <= '0;
    end else if (f12) begin
      light_level <= light_next;
    end
  end

  always_ff @(posedge clk) begin
    if (f12) begin
      s2_active <= s1_active;
      s2_flag   <= s1_flag;
      s2_cmd    <= cmd_next;
    end
  end

  // stage 3: steer angle snap or slew, output register
  logic signed [GW-1:0] steer_now;
  logic signed [GW:0]   diff;
  logic signed [GW:0]   band;
  logic signed [GW:0]   stepped;
  logic signed [GW-1:0] steer_next;
  logic [1:0]           poll_next;

  always_comb begin
    diff      = 14'(s2_cmd) - 14'(steer_now);
    band      = $signed({6'd0, snap_band});
    poll_next = s2_active ? nwsc_pkg::POLL_ARMED : nwsc_pkg::POLL_IDLE;
    stepped   = 14'(steer_now);
    if ((diff < band) && (diff > -band)) begin
      stepped = 14'(s2_cmd);
    end else if (s2_cmd < steer_now) begin
      stepped   = 14'(steer_now) - $signed({6'd0, slew_step});
      poll_next = nwsc_pkg::POLL_SLEW;
    end else if (s2_cmd > steer_now) begin
      stepped   = 14'(steer_now) + $signed({6'd0, slew_step});
      poll_next = nwsc_pkg::POLL_SLEW;
    end
    if (stepped > 14'(nwsc_pkg::STEER_LIMIT)) begin
      steer_next = nwsc_pkg::STEER_LIMIT;
    end else if (stepped < -14'(nwsc_pkg::STEER_LIMIT)) begin
      steer_next = -nwsc_pkg::STEER_LIMIT;
    end else begin
      steer_next = stepped[GW-1:0];
    end
  end

  logic signed [GW-1:0]         o_angle;
  logic                         o_flag;
  logic [nwsc_pkg::LIGHT_W-1:0] o_light;
  logic [1:0]                   o_poll;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_now <= '0;
    end else if (f23) begin
      steer_now <= steer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (f23) begin
      o_angle <= steer_next;
      o_flag  <= s2_flag;
      o_light <= light_level;
      o_poll  <= poll_next;
    end
  end

  // steering-on flag and annunciator always set and clear together
  assign m_tvalid = v3;
  assign m_tdata  = {7'd0, o_poll, o_light, o_flag, o_flag, o_angle};

endmodule
